// ===== hw/rtl/csvt_pkg.sv =====
// Shared types and constants for the delimited-text row tokenizer.
// Holds request/result payload structs, configuration struct and state codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package csvt_pkg;

  localparam int MAX_COLUMNS = 256;
  localparam int COUNT_BITS  = 32;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int CC_W        = COL_W + 1;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int OUT_CNT_W   = 32;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef enum logic [1:0] {
    PH_SKIP  = 2'd0,
    PH_PARSE = 2'd1,
    PH_DONE  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    Q_OUT   = 2'd0,
    Q_AFTER = 2'd1,
    Q_IN    = 2'd2
  } quote_t;

  typedef enum logic [1:0] {
    EV_CONTENT   = 2'd0,
    EV_FIELD_END = 2'd1,
    EV_FINISHED  = 2'd2,
    EV_ERROR     = 2'd3
  } evt_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_BAD_QUOTE   = 3'd1,
    ERR_TOO_MANY    = 3'd2,
    ERR_EARLY_EOL   = 3'd3,
    ERR_UNFINISHED  = 3'd4,
    ERR_FEW_ROWS    = 3'd5
  } err_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELIMITER    = 3'd0,
    REG_COLUMN_COUNT = 3'd1,
    REG_ROWS_TO_SKIP = 3'd2,
    REG_ROWS_TO_READ = 3'd3,
    REG_BYTE_LIMIT   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_input;
  } csvt_in_t;

  typedef struct packed {
    evt_kind_t              event_kind;
    logic [7:0]             content_byte;
    logic [COL_W-1:0]       column_index;
    logic [OUT_CNT_W-1:0]   row_index;
    logic                   last_in_row;
    err_code_t              error_code;
    logic [OUT_CNT_W-1:0]   byte_position;
  } csvt_out_t;

  typedef struct packed {
    logic [7:0]            delimiter;
    logic [CC_W-1:0]       column_count;
    logic [CFG_DATA_W-1:0] rows_to_read;
    logic [CFG_DATA_W-1:0] byte_limit;
  } csvt_cfg_t;

  // A write to the skip register, offered to the parser for a skip-count reload.
  typedef struct packed {
    logic                  load;
    logic [COUNT_BITS-1:0] value;
  } skip_load_t;

endpackage

`default_nettype wire

// ===== hw/rtl/csvt_cfg_regs.sv =====
// Configuration register file of the row tokenizer.
// Depends on csvt_pkg for the register indexes and the configuration struct.
`timescale 1ns / 1ps
`default_nettype none

module csvt_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [csvt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [csvt_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output csvt_pkg::csvt_cfg_t                     cfg,
  output csvt_pkg::skip_load_t                    skip_ld
);
  import csvt_pkg::*;

  csvt_cfg_t cfg_r;
  csvt_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_DELIMITER:    cfg_nxt.delimiter    = cfg_wdata[7:0];
        REG_COLUMN_COUNT: cfg_nxt.column_count = cfg_wdata[CC_W-1:0];
        // The skip count is only needed at the write itself and goes out on skip_ld.
        REG_ROWS_TO_SKIP: cfg_nxt = cfg_r;
        REG_ROWS_TO_READ: cfg_nxt.rows_to_read = cfg_wdata;
        REG_BYTE_LIMIT:   cfg_nxt.byte_limit   = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delimiter    <= 8'd44;
      cfg_r.column_count <= CC_W'(1);
      cfg_r.rows_to_read <= '0;
      cfg_r.byte_limit   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg           = cfg_r;
  assign skip_ld.load  = cfg_we && (cfg_index == REG_ROWS_TO_SKIP);
  assign skip_ld.value = COUNT_BITS'(cfg_wdata);

endmodule

`default_nettype wire

// ===== hw/rtl/csvt_in_reg.sv =====
// Input register stage of the row tokenizer: holds one accepted request.
// Depends on csvt_pkg for the request payload struct.
`timescale 1ns / 1ps
`default_nettype none

module csvt_in_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  csvt_pkg::csvt_in_t in_data,
  input  wire logic          advance,
  output logic               s_valid,
  output csvt_pkg::csvt_in_t s_data
);
  import csvt_pkg::*;

  logic     s_valid_r;
  logic     s_valid_nxt;
  csvt_in_t s_data_r;

  // The held request leaves in the same cycle a new one can enter.
  assign in_ready = !s_valid_r || advance;

  always_comb begin
    s_valid_nxt = s_valid_r;
    if (in_valid && in_ready) begin
      s_valid_nxt = 1'b1;
    end else if (advance) begin
      s_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else begin
      s_valid_r <= s_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_data_r <= in_data;
    end
  end

  assign s_valid = s_valid_r;
  assign s_data  = s_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/csvt_core.sv =====
// Parser state and per-byte decision logic of the row tokenizer.
// Depends on csvt_pkg for state codes, payload and configuration structs.
`timescale 1ns / 1ps
`default_nettype none

module csvt_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           fire,
  input  csvt_pkg::csvt_in_t  item,
  input  csvt_pkg::csvt_cfg_t cfg,
  input  csvt_pkg::skip_load_t skip_ld,
  output logic                res_valid,
  output csvt_pkg::csvt_out_t res
);
  import csvt_pkg::*;

  localparam int CNT_W = COUNT_BITS;

  phase_t           phase_r,     phase_nxt;
  logic [CNT_W-1:0] skip_left_r, skip_left_nxt;
  quote_t           quote_r,     quote_nxt;
  logic             fhc_r,       fhc_nxt;
  logic [COL_W-1:0] col_r,       col_nxt;
  logic [CNT_W-1:0] row_r,       row_nxt;
  logic [CNT_W-1:0] skipped_r,   skipped_nxt;
  logic [CNT_W-1:0] bytes_r,     bytes_nxt;

  logic [CC_W-1:0]  cc_eff;
  logic [CC_W-1:0]  col_plus;
  logic [CNT_W-1:0] row_limit;
  logic [CNT_W-1:0] byte_lim;
  logic [CNT_W:0]   rows_left;
  logic             rows_met;
  logic             limit_hit;
  phase_t           phase_eff;
  logic [7:0]       b;

  assign b         = item.text_byte;
  assign cc_eff    = (cfg.column_count > CC_W'(MAX_COLUMNS)) ? CC_W'(MAX_COLUMNS)
                                                            : cfg.column_count;
  assign col_plus  = {1'b0, col_r} + CC_W'(1);
  assign row_limit = CNT_W'(cfg.rows_to_read);
  assign byte_lim  = CNT_W'(cfg.byte_limit);

  // Lines still allowed; a borrow means the skipped lines alone passed the limit.
  assign rows_left = {1'b0, row_limit} - {1'b0, skipped_r};
  assign rows_met  = rows_left[CNT_W] || (rows_left[CNT_W-1:0] == '0) ||
                     (row_r >= rows_left[CNT_W-1:0]);
  assign limit_hit = ((byte_lim != '0) && (bytes_r >= byte_lim)) ||
                     ((row_limit != '0) && rows_met);
  assign phase_eff = ((phase_r == PH_SKIP) && (skip_left_r == '0)) ? PH_PARSE : phase_r;

  always_comb begin
    logic      act_append;
    logic      act_end;
    logic      act_drop;
    logic      act_fail;
    logic      act_finish;
    logic      end_last;
    err_code_t fail_code;

    act_append = 1'b0;
    act_end    = 1'b0;
    act_drop   = 1'b0;
    act_fail   = 1'b0;
    act_finish = 1'b0;
    end_last   = 1'b0;
    fail_code  = ERR_NONE;

    phase_nxt     = phase_r;
    skip_left_nxt = skip_left_r;
    quote_nxt     = quote_r;
    fhc_nxt       = fhc_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    skipped_nxt   = skipped_r;
    bytes_nxt     = bytes_r;

    res_valid         = 1'b0;
    res.event_kind    = EV_CONTENT;
    res.content_byte  = 8'd0;
    res.column_index  = col_r;
    res.row_index     = OUT_CNT_W'(row_r);
    res.last_in_row   = 1'b0;
    res.error_code    = ERR_NONE;
    res.byte_position = OUT_CNT_W'(bytes_r);

    if (phase_r != PH_DONE) begin
      if (item.end_of_input) begin
        act_finish = 1'b1;
      end else begin
        phase_nxt = phase_eff;
        if (limit_hit) begin
          act_finish = 1'b1;
        end else if (phase_eff == PH_SKIP) begin
          bytes_nxt = bytes_r + CNT_W'(1);
          if (b == CH_NL) begin
            skip_left_nxt = skip_left_r - CNT_W'(1);
            skipped_nxt   = skipped_r + CNT_W'(1);
            if (skip_left_r == CNT_W'(1)) begin
              phase_nxt = PH_PARSE;
            end
          end
        end else if (b == cfg.delimiter) begin
          // The delimiter wins over every other rule unless inside quotes.
          if (quote_r == Q_IN) begin
            act_append = 1'b1;
          end else if (col_plus < cc_eff) begin
            act_end = 1'b1;
          end else begin
            act_fail  = 1'b1;
            fail_code = ERR_TOO_MANY;
          end
        end else begin
          unique case (b)
            CH_NL: begin
              if (quote_r == Q_IN) begin
                act_fail  = 1'b1;
                fail_code = ERR_BAD_QUOTE;
              end else if (col_plus == cc_eff) begin
                act_end  = 1'b1;
                end_last = 1'b1;
              end else begin
                act_fail  = 1'b1;
                fail_code = ERR_EARLY_EOL;
              end
            end
            CH_SPACE, CH_TAB: begin
              if (quote_r == Q_AFTER) begin
                act_fail  = 1'b1;
                fail_code = ERR_BAD_QUOTE;
              end else if ((quote_r != Q_IN) && !fhc_r) begin
                act_drop = 1'b1;
              end else begin
                act_append = 1'b1;
              end
            end
            CH_QUOTE: begin
              if (quote_r == Q_AFTER) begin
                // Doubled quote inside a quoted field is a literal quote.
                quote_nxt  = Q_IN;
                act_append = 1'b1;
              end else if (quote_r == Q_IN) begin
                quote_nxt = Q_AFTER;
                act_drop  = 1'b1;
              end else if (fhc_r) begin
                act_append = 1'b1;
              end else begin
                quote_nxt = Q_IN;
                act_drop  = 1'b1;
              end
            end
            default: begin
              if (quote_r == Q_AFTER) begin
                act_fail  = 1'b1;
                fail_code = ERR_BAD_QUOTE;
              end else begin
                act_append = 1'b1;
              end
            end
          endcase
        end
      end
    end

    if (act_finish) begin
      if (col_r != '0) begin
        act_fail  = 1'b1;
        fail_code = ERR_UNFINISHED;
      end else if ((row_limit != '0) && !rows_met) begin
        act_fail  = 1'b1;
        fail_code = ERR_FEW_ROWS;
      end else begin
        phase_nxt      = PH_DONE;
        res_valid      = 1'b1;
        res.event_kind = EV_FINISHED;
      end
    end

    if (act_fail) begin
      phase_nxt      = PH_DONE;
      res_valid      = 1'b1;
      res.event_kind = EV_ERROR;
      res.error_code = fail_code;
    end

    if (act_append) begin
      fhc_nxt          = 1'b1;
      bytes_nxt        = bytes_r + CNT_W'(1);
      res_valid        = 1'b1;
      res.event_kind   = EV_CONTENT;
      res.content_byte = b;
    end

    if (act_drop) begin
      bytes_nxt = bytes_r + CNT_W'(1);
    end

    if (act_end) begin
      quote_nxt       = Q_OUT;
      fhc_nxt         = 1'b0;
      bytes_nxt       = bytes_r + CNT_W'(1);
      res_valid       = 1'b1;
      res.event_kind  = EV_FIELD_END;
      res.last_in_row = end_last;
      if (end_last) begin
        col_nxt = '0;
        row_nxt = row_r + CNT_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SKIP;
      skip_left_r <= '0;
      quote_r     <= Q_OUT;
      fhc_r       <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      skipped_r   <= '0;
      bytes_r     <= '0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      skip_left_r <= skip_left_nxt;
      quote_r     <= quote_nxt;
      fhc_r       <= fhc_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      skipped_r   <= skipped_nxt;
      bytes_r     <= bytes_nxt;
    end else if (skip_ld.load && (phase_r == PH_SKIP) && (bytes_r == '0)) begin
      // A new skip count takes effect only before the first byte is taken.
      skip_left_r <= skip_ld.value;
    end
  end

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE) |-> !res_valid)
    else $error("result produced after parsing stopped");

  a_error_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res_valid && (res.event_kind == EV_ERROR)) |=> (phase_r == PH_DONE))
    else $error("error result did not stop the parser");

  a_quote_path: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (quote_r == Q_OUT)) |=> (quote_r != Q_AFTER))
    else $error("quote tracker left the outside state for the closing state");

  a_bytes_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(bytes_r))
    else $error("byte counter moved without a request");

endmodule

`default_nettype wire

// ===== hw/rtl/csvt_out_reg.sv =====
// Result register of the row tokenizer: holds one result until it is taken.
// Depends on csvt_pkg for the result payload struct.
`timescale 1ns / 1ps
`default_nettype none

module csvt_out_reg (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           advance,
  input  wire logic           res_valid,
  input  csvt_pkg::csvt_out_t res,
  output logic                space,
  output logic                out_valid,
  input  wire logic           out_ready,
  output csvt_pkg::csvt_out_t out_data
);
  import csvt_pkg::*;

  logic      out_valid_r;
  logic      out_valid_nxt;
  csvt_out_t out_data_r;

  assign space = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = res_valid;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/csv_row_tokenizer.sv =====
// Delimited-text row tokenizer: one byte per request, field events out.
// Usage:
//   Requests (in_valid/in_ready/in_data) carry one text byte or an end mark.
//   Results (out_valid/out_ready/out_data) are content bytes, field ends,
//   a finish event or the first error; a request gives at most one result.
//   Configuration writes (cfg_we/cfg_index/cfg_wdata) must be made while no
//   request is in flight; the block does not enforce it.
// Timing:
//   A request is registered in the input register on acceptance and decided
//   by the parser once the result register has space; its result is then
//   registered in the result register. One request is taken every cycle
//   while out_ready stays high; the limit is the parser register update.
// Reset:
//   rst_n (synchronous) restores the register defaults and clears all parser
//   state and the valid bits of both pipeline registers. After an error or
//   finish the block takes requests but stays silent until the next reset.
// Backpressure:
//   While out_ready is low with a result held, the decision stage stalls and
//   in_ready drops once the input register is full; nothing is lost.
// Depends on csvt_pkg and the csvt_* submodules.
`timescale 1ns / 1ps
`default_nettype none

module csv_row_tokenizer (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  csvt_pkg::csvt_in_t                   in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output csvt_pkg::csvt_out_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [csvt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [csvt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import csvt_pkg::*;

  csvt_cfg_t  cfg;
  skip_load_t skip_ld;
  logic       s_valid;
  csvt_in_t   s_data;
  logic       space;
  logic       advance;
  logic       res_valid;
  csvt_out_t  res;

  assign advance = s_valid && space;

  csvt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .skip_ld   (skip_ld)
  );

  csvt_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .advance  (advance),
    .s_valid  (s_valid),
    .s_data   (s_data)
  );

  csvt_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .item      (s_data),
    .cfg       (cfg),
    .skip_ld   (skip_ld),
    .res_valid (res_valid),
    .res       (res)
  );

  csvt_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
